// ===== sv/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg
// shared types and constants of the byte stream reassembler
// ----------------------------------------------------------------------------
package brs_pkg;

   localparam int RING_DEPTH = 4096;
   localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_MIN_W  = $clog2(RING_DEPTH + 1);
   localparam int CNT_W      = (CNT_MIN_W > 13) ? CNT_MIN_W : 13;

   localparam int INDEX_W   = 64;
   localparam int BYTE_W    = 8;
   localparam int ROOM_W    = 13;
   localparam int PENDING_W = 13;

   typedef enum logic [1:0] {
      FUNC_DATA  = 2'd0,
      FUNC_DRAIN = 2'd1,
      FUNC_END   = 2'd2
   } func_type;

   typedef struct packed {
      logic              held;
      logic [BYTE_W-1:0] value;
   } slot_type;

endpackage

// ===== sv/byte_stream_reassembler_top.sv =====
// ----------------------------------------------------------------------------
// byte_stream_reassembler_top
// reorders indexed stream bytes into an in-order stream through a ring store
// ----------------------------------------------------------------------------
// One item per clock: a transfer is taken whenever start is high and busy is
// low, and its result is registered through s1_valid_ff and rsp_strobe_ff and
// shows for one cycle on rsp_strobe; the receiver cannot stall it. The rate is
// set by the single ring memory, read as the item is taken, with the write of
// the item before forwarded to the read. After reset the ring is cleared, one
// slot a cycle, so busy stays high until every slot is clear, before the first transfer.
// ----------------------------------------------------------------------------
module byte_stream_reassembler_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_func,
   input  logic [brs_pkg::INDEX_W-1:0]   req_stream_index,
   input  logic [brs_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [brs_pkg::ROOM_W-1:0]    req_room,
   output logic                          rsp_strobe,
   output logic                          rsp_byte_valid,
   output logic [brs_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                          rsp_stream_closed,
   output logic [brs_pkg::PENDING_W-1:0] rsp_pending_bytes
);

   localparam int AW   = brs_pkg::RING_AW;
   localparam int IW   = brs_pkg::INDEX_W;
   localparam int CW   = brs_pkg::CNT_W;
   localparam int PW   = brs_pkg::PENDING_W;
   localparam logic [AW:0]   DEPTH_X = (AW+1)'(brs_pkg::RING_DEPTH);
   localparam logic [AW-1:0] LAST    = AW'(brs_pkg::RING_DEPTH - 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(brs_pkg::RING_DEPTH);
   localparam logic [CW-1:0] PEND_SAT = CW'((1 << PW) - 1);

   // ring memory
   brs_pkg::slot_type ring_mem [brs_pkg::RING_DEPTH];

   // clearing pass
   logic          clr_ff;
   logic [AW-1:0] clr_cnt_ff;

   // stream state
   logic [IW-1:0] next_exp_ff, next_exp_in;
   logic [AW-1:0] slot_ne_ff, slot_ne_in;
   logic          final_seen_ff, final_seen_in;
   logic [IW-1:0] final_idx_ff, final_idx_in;
   logic          closed_ff, closed_in;
   logic [CW-1:0] held_ff, held_in;

   // item in flight
   logic                        s1_valid_ff;
   brs_pkg::func_type           s1_func_ff;
   logic [IW-1:0]               s1_index_ff;
   logic [brs_pkg::BYTE_W-1:0]  s1_byte_ff;
   logic [brs_pkg::ROOM_W-1:0]  s1_room_ff;
   logic [AW-1:0]               s1_slot_ff;

   // read port with forwarding
   brs_pkg::slot_type rd_word_ff;
   brs_pkg::slot_type byp_word_ff;
   logic              byp_ff;
   brs_pkg::slot_type cur_word;

   // write port
   logic              we;
   logic [AW-1:0]     waddr;
   brs_pkg::slot_type wdata;

   // result registers
   logic                        rsp_strobe_ff;
   logic                        rsp_valid_ff;
   logic [brs_pkg::BYTE_W-1:0]  rsp_byte_ff;
   logic                        rsp_closed_ff;
   logic [PW-1:0]               rsp_pend_ff;

   logic          accept;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] dist_low;
   logic [AW:0]   slot_sum;
   logic [IW:0]   diff;
   logic          in_window;
   logic          do_insert;
   logic          do_release;

   assign busy   = clr_ff;
   assign accept = start && !clr_ff;

   assign cur_word = byp_ff ? byp_word_ff : rd_word_ff;

   // window check and slot decisions for the item in flight
   always_comb begin
      diff      = {1'b0, s1_index_ff} - {1'b0, next_exp_ff};
      in_window = !diff[IW]
                  && (diff[IW-1:0] < IW'(s1_room_ff))
                  && (diff[IW-1:0] < IW'(brs_pkg::RING_DEPTH));
      do_insert  = s1_valid_ff && (s1_func_ff == brs_pkg::FUNC_DATA) && !closed_ff
                   && in_window && !cur_word.held;
      do_release = s1_valid_ff && (s1_func_ff == brs_pkg::FUNC_DRAIN) && !closed_ff
                   && cur_word.held;
   end

   // next stream state
   always_comb begin
      next_exp_in   = next_exp_ff;
      slot_ne_in    = slot_ne_ff;
      final_seen_in = final_seen_ff;
      final_idx_in  = final_idx_ff;
      held_in       = held_ff;
      if (do_release) begin
         next_exp_in = next_exp_ff + IW'(1);
         slot_ne_in  = (slot_ne_ff == LAST) ? '0 : slot_ne_ff + AW'(1);
         held_in     = held_ff - CW'(1);
      end
      if (do_insert) begin
         held_in = held_ff + CW'(1);
      end
      if (s1_valid_ff && (s1_func_ff == brs_pkg::FUNC_END)) begin
         final_seen_in = 1'b1;
         final_idx_in  = s1_index_ff;
      end
      closed_in = closed_ff || (final_seen_in && (next_exp_in == final_idx_in));
   end

   // write port select
   always_comb begin
      we    = 1'b0;
      waddr = s1_slot_ff;
      wdata = '0;
      if (clr_ff) begin
         we    = 1'b1;
         waddr = clr_cnt_ff;
      end else if (do_insert) begin
         we          = 1'b1;
         waddr       = s1_slot_ff;
         wdata.held  = 1'b1;
         wdata.value = s1_byte_ff;
      end else if (do_release) begin
         we    = 1'b1;
         waddr = slot_ne_ff;
      end
   end

   // read address for the item being taken, against the state it will see
   always_comb begin
      dist_low = req_stream_index[AW-1:0] - next_exp_in[AW-1:0];
      slot_sum = {1'b0, slot_ne_in} + {1'b0, dist_low};
      if (slot_sum >= DEPTH_X) begin
         slot_sum = slot_sum - DEPTH_X;
      end
      case (brs_pkg::func_type'(req_func))
         brs_pkg::FUNC_DRAIN: rd_addr = slot_ne_in;
         brs_pkg::FUNC_DATA:  rd_addr = slot_sum[AW-1:0];
         default:             rd_addr = slot_ne_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         ring_mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_word_ff  <= ring_mem[rd_addr];
      byp_ff      <= we && (waddr == rd_addr);
      byp_word_ff <= wdata;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= 1'b1;
         clr_cnt_ff    <= '0;
         next_exp_ff   <= '0;
         slot_ne_ff    <= '0;
         final_seen_ff <= 1'b0;
         final_idx_ff  <= '0;
         closed_ff     <= 1'b0;
         held_ff       <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (clr_ff) begin
            if (clr_cnt_ff == LAST) begin
               clr_ff <= 1'b0;
            end else begin
               clr_cnt_ff <= clr_cnt_ff + AW'(1);
            end
         end
         next_exp_ff   <= next_exp_in;
         slot_ne_ff    <= slot_ne_in;
         final_seen_ff <= final_seen_in;
         final_idx_ff  <= final_idx_in;
         closed_ff     <= closed_in;
         held_ff       <= held_in;
         s1_valid_ff   <= accept;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff  <= brs_pkg::func_type'(req_func);
         s1_index_ff <= req_stream_index;
         s1_byte_ff  <= req_data_byte;
         s1_room_ff  <= req_room;
         s1_slot_ff  <= rd_addr;
      end
      if (s1_valid_ff) begin
         rsp_valid_ff  <= do_release;
         rsp_byte_ff   <= do_release ? cur_word.value : '0;
         rsp_closed_ff <= closed_in;
         rsp_pend_ff   <= (held_in > PEND_SAT) ? '1 : held_in[PW-1:0];
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_byte_valid    = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_stream_closed = rsp_closed_ff;
   assign rsp_pending_bytes = rsp_pend_ff;

`ifndef SYNTH
   a_closed_sticks: assert property (@(posedge clock) disable iff (reset)
      closed_ff |=> closed_ff)
      else $error("closed flag dropped without reset");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_MAX)
      else $error("held count above ring depth");

   a_no_item_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !s1_valid_ff && !rsp_strobe_ff)
      else $error("item in flight during clearing pass");

   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(s1_valid_ff))
      else $error("result without an item in flight");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the byte stream reassembler
// ----------------------------------------------------------------------------
// Bytes, drain ticks and end marks are sent through the start/busy command
// port. Each accepted transfer is run through a cycle-free model of the
// reorder ring kept inside the bench, and its status is queued. A monitor
// compares each rsp_strobe transfer with the oldest queued status, field by
// field. A short directed pass covers the window edges, then shuffled byte
// runs with duplicates, drains and noise are sent, and the stream is closed
// last because only a reset reopens it.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [1:0]  FUNC_SPARE = 2'd3;
   localparam int unsigned END_GUARD  = 1_000_000;

   typedef struct packed {
      logic                          byte_valid;
      logic [brs_pkg::BYTE_W-1:0]    out_byte;
      logic                          stream_closed;
      logic [brs_pkg::PENDING_W-1:0] pending_bytes;
   } stream_status_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [1:0]                    req_func;
   logic [brs_pkg::INDEX_W-1:0]   req_stream_index;
   logic [brs_pkg::BYTE_W-1:0]    req_data_byte;
   logic [brs_pkg::ROOM_W-1:0]    req_room;
   logic                          rsp_strobe;
   logic                          rsp_byte_valid;
   logic [brs_pkg::BYTE_W-1:0]    rsp_out_byte;
   logic                          rsp_stream_closed;
   logic [brs_pkg::PENDING_W-1:0] rsp_pending_bytes;

   byte_stream_reassembler_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_stream_index  (req_stream_index),
      .req_data_byte     (req_data_byte),
      .req_room          (req_room),
      .rsp_strobe        (rsp_strobe),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_stream_closed (rsp_stream_closed),
      .rsp_pending_bytes (rsp_pending_bytes)
   );

   logic [brs_pkg::BYTE_W-1:0]  ring_value [brs_pkg::RING_DEPTH];
   bit                          ring_held  [brs_pkg::RING_DEPTH];
   logic [brs_pkg::INDEX_W-1:0] next_idx   = '0;
   logic [brs_pkg::INDEX_W-1:0] final_idx  = '0;
   bit                          final_seen = 1'b0;
   bit                          closed     = 1'b0;
   int                          held_total = 0;
   bit                          last_released = 1'b0;

   stream_status_type status_queue[$];
   stream_status_type oldest;
   int                errors     = 0;
   int                items_sent = 0;
   bit                no_gaps    = 1'b0;

   always #2 clock = ~clock;

   function automatic logic [brs_pkg::INDEX_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic stream_status_type reassemble(
         input logic [1:0]                  func,
         input logic [brs_pkg::INDEX_W-1:0] idx,
         input logic [brs_pkg::BYTE_W-1:0]  value,
         input logic [brs_pkg::ROOM_W-1:0]  room);
      stream_status_type           res;
      logic [brs_pkg::INDEX_W-1:0] window;
      int unsigned                 slot;
      res.byte_valid = 1'b0;
      res.out_byte   = '0;
      case (func)
         brs_pkg::FUNC_DATA: begin
            window = (room > brs_pkg::RING_DEPTH) ? 64'(brs_pkg::RING_DEPTH) : 64'(room);
            slot   = 32'(idx % brs_pkg::RING_DEPTH);
            if (!closed && idx >= next_idx && (idx - next_idx) < window
                && !ring_held[slot]) begin
               ring_value[slot] = value;
               ring_held[slot]  = 1'b1;
               held_total++;
            end
         end
         brs_pkg::FUNC_DRAIN: begin
            slot = 32'(next_idx % brs_pkg::RING_DEPTH);
            if (!closed && ring_held[slot]) begin
               res.byte_valid  = 1'b1;
               res.out_byte    = ring_value[slot];
               ring_held[slot] = 1'b0;
               held_total--;
               next_idx++;
            end
         end
         brs_pkg::FUNC_END: begin
            final_seen = 1'b1;
            final_idx  = idx;
         end
         default: ;
      endcase
      if (final_seen && next_idx == final_idx)
         closed = 1'b1;
      res.stream_closed = closed;
      res.pending_bytes = (held_total > 8191) ? '1 : brs_pkg::PENDING_W'(held_total);
      last_released     = res.byte_valid;
      return res;
   endfunction

   task automatic send_item(input logic [1:0]                  func,
                            input logic [brs_pkg::INDEX_W-1:0] idx,
                            input logic [brs_pkg::BYTE_W-1:0]  value,
                            input logic [brs_pkg::ROOM_W-1:0]  room);
      while (!no_gaps && $urandom_range(0, 99) < 33) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_func         <= func;
      req_stream_index <= idx;
      req_data_byte    <= value;
      req_room         <= room;
      do @(posedge clock); while (busy);
      status_queue.push_back(reassemble(func, idx, value, room));
      items_sent++;
   endtask

   // tick until a tick releases nothing
   task automatic drain_all();
      do send_item(brs_pkg::FUNC_DRAIN, rand64(), 8'($urandom),
                   brs_pkg::ROOM_W'($urandom));
      while (last_released);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (status_queue.size() == 0) begin
            errors++;
            $display("%0t: result transfer with none expected, actual pending %0d",
                     $time, rsp_pending_bytes);
         end else begin
            oldest = status_queue.pop_front();
            check_field("byte_valid", 64'(oldest.byte_valid), 64'(rsp_byte_valid));
            check_field("out_byte", 64'(oldest.out_byte), 64'(rsp_out_byte));
            check_field("stream_closed", 64'(oldest.stream_closed),
                        64'(rsp_stream_closed));
            check_field("pending_bytes", 64'(oldest.pending_bytes),
                        64'(rsp_pending_bytes));
         end
      end
   end

   task automatic test_window_edges();
      send_item(brs_pkg::FUNC_DRAIN, '0, '0, '0);
      send_item(brs_pkg::FUNC_DATA, '0, 8'hFF, '0);
      send_item(brs_pkg::FUNC_DATA, '0, 8'h00, 13'd1);
      send_item(brs_pkg::FUNC_DATA, '0, 8'hAA, 13'd1);
      send_item(brs_pkg::FUNC_DATA, 64'd1, 8'h55, 13'd1);
      send_item(brs_pkg::FUNC_DATA, 64'd4095, 8'h5A, '1);
      send_item(brs_pkg::FUNC_DATA, 64'd4096, 8'hA5, '1);
      send_item(brs_pkg::FUNC_DATA, '1, 8'hFF, 13'd4096);
      send_item(FUNC_SPARE, '1, '1, '1);
      send_item(brs_pkg::FUNC_END, '1, '0, '0);
      send_item(brs_pkg::FUNC_END, 64'd100, '0, '0);
      send_item(brs_pkg::FUNC_DRAIN, '1, '1, '1);
      send_item(brs_pkg::FUNC_DRAIN, '0, '0, '0);
      send_item(brs_pkg::FUNC_DATA, '0, 8'h3C, 13'd10);
      send_item(brs_pkg::FUNC_DATA, 64'd4096, 8'hC3, 13'd4096);
      send_item(brs_pkg::FUNC_DATA, 64'd2, 8'h81, 13'd2);
      send_item(brs_pkg::FUNC_DATA, 64'd1, 8'h7E, 13'd2);
      send_item(brs_pkg::FUNC_DRAIN, '0, '0, '0);
      send_item(brs_pkg::FUNC_DRAIN, '0, '0, '0);
      send_item(brs_pkg::FUNC_DRAIN, '0, '0, '0);
      // end index behind the stream, never reached
      send_item(brs_pkg::FUNC_END, '0, '0, '0);
   endtask

   task automatic test_out_of_order_segments();
      int unsigned                 order[$];
      int unsigned                 pick;
      int unsigned                 tmp;
      int                          seg_len;
      int                          segments;
      logic [brs_pkg::INDEX_W-1:0] base;
      logic [brs_pkg::INDEX_W-1:0] idx;
      logic [brs_pkg::ROOM_W-1:0]  room;
      segments = 0;
      while (items_sent < 2000) begin
         no_gaps = (items_sent >= 700 && items_sent < 1000);
         if ($urandom_range(0, 99) < 75) begin
            seg_len = (segments == 5) ? 300 : $urandom_range(1, 24);
            segments++;
            base = next_idx;
            order.delete();
            for (int i = 0; i < seg_len; i++)
               order.push_back(i);
            for (int i = seg_len - 1; i > 0; i--) begin
               pick        = $urandom_range(0, i);
               tmp         = order[i];
               order[i]    = order[pick];
               order[pick] = tmp;
            end
            repeat ($urandom_range(0, 3))
               order.push_back($urandom_range(0, seg_len - 1));
            foreach (order[i]) begin
               if ($urandom_range(0, 9) == 0)
                  room = brs_pkg::ROOM_W'($urandom_range(0, order[i]));
               else
                  room = brs_pkg::ROOM_W'($urandom_range(order[i] + 1, 8191));
               send_item(brs_pkg::FUNC_DATA, base + order[i], 8'($urandom), room);
               if ($urandom_range(0, 9) == 0)
                  send_item(brs_pkg::FUNC_DRAIN, rand64(), 8'($urandom),
                            brs_pkg::ROOM_W'($urandom));
            end
            drain_all();
         end else begin
            case ($urandom_range(0, 6))
               0: send_item(brs_pkg::FUNC_DATA, next_idx - 64'($urandom_range(1, 64)),
                            8'($urandom), brs_pkg::ROOM_W'($urandom));
               1: begin
                  room = brs_pkg::ROOM_W'($urandom);
                  send_item(brs_pkg::FUNC_DATA, next_idx + room + $urandom_range(0, 50),
                            8'($urandom), room);
               end
               2: send_item(brs_pkg::FUNC_DATA, rand64(), 8'($urandom),
                            brs_pkg::ROOM_W'($urandom));
               3: send_item(brs_pkg::FUNC_DATA, next_idx + $urandom_range(0, 8191),
                            8'($urandom), brs_pkg::ROOM_W'($urandom));
               4: begin
                  do idx = rand64(); while (idx - next_idx < END_GUARD);
                  send_item(brs_pkg::FUNC_END, idx, 8'($urandom),
                            brs_pkg::ROOM_W'($urandom));
               end
               5: send_item(FUNC_SPARE, rand64(), 8'($urandom),
                            brs_pkg::ROOM_W'($urandom));
               default: drain_all();
            endcase
         end
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_stream_close();
      logic [brs_pkg::INDEX_W-1:0] base;
      base = next_idx;
      for (int i = 0; i < 5; i++)
         send_item(brs_pkg::FUNC_DATA, base + i, 8'($urandom), 13'd4096);
      send_item(brs_pkg::FUNC_END, base + 3, 8'($urandom), brs_pkg::ROOM_W'($urandom));
      repeat (3) send_item(brs_pkg::FUNC_DRAIN, rand64(), 8'($urandom),
                           brs_pkg::ROOM_W'($urandom));
      drain_all();
      send_item(brs_pkg::FUNC_DATA, base + 3, 8'($urandom), 13'd4096);
      send_item(brs_pkg::FUNC_DATA, next_idx, 8'($urandom), '1);
      send_item(brs_pkg::FUNC_END, '1, 8'($urandom), brs_pkg::ROOM_W'($urandom));
      send_item(FUNC_SPARE, rand64(), 8'($urandom), brs_pkg::ROOM_W'($urandom));
      send_item(brs_pkg::FUNC_DRAIN, rand64(), 8'($urandom), brs_pkg::ROOM_W'($urandom));
   endtask

   initial begin
      int wait_cycles;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_func         <= brs_pkg::FUNC_DATA;
      req_stream_index <= '0;
      req_data_byte    <= '0;
      req_room         <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_window_edges();
      test_out_of_order_segments();
      test_stream_close();
      start <= 1'b0;
      wait_cycles = 0;
      while (status_queue.size() != 0 && wait_cycles < 100) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      if (status_queue.size() != 0)
         $display("%0t: %0d results never arrived", $time, status_queue.size());
      if (errors == 0 && status_queue.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
